@@ hdl/f2pcm_pkg.sv @@
// shared types and constants for the float to pcm sample encoder
package f2pcm_pkg;

  typedef enum logic [1:0] {
    DEPTH_8  = 2'd0,
    DEPTH_16 = 2'd1,
    DEPTH_24 = 2'd2,
    DEPTH_32 = 2'd3
  } depth_e;

  localparam depth_e DepthReset = DEPTH_16;

  // first stage to second stage: product and rounding info
  typedef struct packed {
    logic        neg;
    logic        sat;
    logic        zero;
    logic [54:0] prod;
    logic [5:0]  sh;
    depth_e      depth;
  } stage_t;

  function automatic logic [31:0] scale_of(depth_e d);
    logic [31:0] s;
    case (d)
      DEPTH_8:  s = 32'h0000_007F;
      DEPTH_16: s = 32'h0000_7FFF;
      DEPTH_24: s = 32'h007F_FFFF;
      DEPTH_32: s = 32'h7FFF_FFFF;
      default:  s = 32'h0000_7FFF;
    endcase
    return s;
  endfunction

endpackage

@@ hdl/f2pcm_mult.sv @@
// first stage: field decode, special cases and magnitude product
module f2pcm_mult import f2pcm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [31:0] float_bits_i,
  input  depth_e      depth_i,
  output logic        vld_o,
  output stage_t      stg_o
);
  logic [7:0]  expo;
  logic [22:0] frac;
  logic [7:0]  shw;
  stage_t      stg_d, stg_q;
  logic        vld_q;

  assign expo = float_bits_i[30:23];
  assign frac = float_bits_i[22:0];
  assign shw  = 8'd150 - expo;

  // decode and multiply mantissa by scale
  always_comb begin
    stg_d.neg   = float_bits_i[31];
    stg_d.depth = depth_i;
    stg_d.sat   = (expo == 8'hFF && frac == 23'd0) || (expo >= 8'd127 && expo != 8'hFF);
    stg_d.zero  = (expo == 8'hFF && frac != 23'd0) || (expo == 8'd0) ||
                  (expo < 8'd127 && shw >= 8'd64);
    stg_d.sh    = shw[5:0];
    stg_d.prod  = 55'({1'b1, frac}) * 55'(scale_of(depth_i));
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else         vld_q <= load_i;
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) stg_q <= stg_d;
  end

  assign vld_o = vld_q;
  assign stg_o = stg_q;
endmodule

@@ hdl/f2pcm_round.sv @@
// second stage: rounding shift, sign and depth packing
module f2pcm_round import f2pcm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        vld_i,
  input  stage_t      stg_i,
  output logic        done_o,
  output logic [31:0] pcm_word_o
);
  logic [55:0] rnd;
  logic [31:0] q, word, res_d, res_q;
  logic        done_q;

  // round half away from zero on magnitude, then apply sign
  always_comb begin
    rnd = {1'b0, stg_i.prod} + (56'd1 << (stg_i.sh - 6'd1));
    if (stg_i.sat)       q = scale_of(stg_i.depth);
    else if (stg_i.zero) q = 32'd0;
    else                 q = 32'(rnd >> stg_i.sh);
    word = stg_i.neg ? (32'd0 - q) : q;
    case (stg_i.depth)
      DEPTH_8:  res_d = {24'd0, word[7:0] + 8'd128};
      DEPTH_16: res_d = {16'd0, word[15:0]};
      DEPTH_24: res_d = {8'd0, word[23:0]};
      DEPTH_32: res_d = word;
      default:  res_d = word;
    endcase
  end

  // strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= vld_i;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (vld_i) res_q <= res_d;
  end

  assign done_o     = done_q;
  assign pcm_word_o = res_q;
endmodule

@@ hdl/float_to_pcm_sample_encode_unit.sv @@
// top level of the float to pcm sample encoder
//  channel | signals                                  | transaction
//  input   | start, busy, float_bits_i                | start high, busy low
//  config  | cfg_valid_i, cfg_ready_o, target_depth_i | valid and ready high
//  result  | done_o, pcm_word_o                       | done high, one cycle
// one sample accepted every cycle; busy is always low
// result is registered first in the multiply stage, then in the round stage
// reset clears valids and sets depth to 16 bits
// the receiver cannot stall; results flow one per cycle
module float_to_pcm_sample_encode_unit import f2pcm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] float_bits_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  target_depth_i,
  output logic        done_o,
  output logic [31:0] pcm_word_o
);
  depth_e depth_q;
  logic   vld;
  stage_t stg;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // depth register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          depth_q <= DepthReset;
    else if (cfg_valid_i) depth_q <= depth_e'(target_depth_i);
  end

  f2pcm_mult u_mult (
    .clk_i, .rst_ni, .load_i(start), .float_bits_i, .depth_i(depth_q),
    .vld_o(vld), .stg_o(stg)
  );

  f2pcm_round u_round (
    .clk_i, .rst_ni, .vld_i(vld), .stg_i(stg), .done_o, .pcm_word_o
  );
endmodule

@@ hdl/f2pcm_checker.sv @@
// port level checks for the encoder, bound to the top level
module f2pcm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [31:0] pcm_word_o
);
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> ##1 done_o) else $error("missing result");
  a_noinv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 2)) else $error("spurious result");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy) else $error("busy raised");
  a_rst: assert property (@(posedge clk_i)
    !rst_ni |=> !done_o) else $error("result after reset");
  // a strobed result carries a known word
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$isunknown(pcm_word_o)) else $error("unknown result word");
endmodule

bind float_to_pcm_sample_encode_unit f2pcm_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .done_o, .pcm_word_o
);

@@ test/tb_top.sv @@
// testbench for the float to pcm sample encoder
module tb_top;
  import f2pcm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] float_bits_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  target_depth_i = '0;
  logic        done_o;
  logic [31:0] pcm_word_o;

  float_to_pcm_sample_encode_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .float_bits_i(float_bits_i), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .target_depth_i(target_depth_i),
    .done_o(done_o), .pcm_word_o(pcm_word_o)
  );

  always #5 clk_i = ~clk_i;

  depth_e      cur_depth;
  logic [31:0] pending_pcm[$];
  int          mismatches = 0;
  int          sender_idle_pct = 0;

  typedef struct {
    logic        is_cfg;
    logic [31:0] value;
    logic        has_exp;
    logic [31:0] exp_word;
  } row_t;

  // encode one float pattern at the current depth
  function automatic logic [31:0] encode_pcm(logic [31:0] f);
    logic        sgn;
    logic [7:0]  ex;
    logic [22:0] fr;
    logic [31:0] full_scale;
    logic [31:0] mag;
    logic [31:0] w;
    logic [63:0] prod;
    int          sh;
    sgn = f[31];
    ex = f[30:23];
    fr = f[22:0];
    case (cur_depth)
      DEPTH_8:  full_scale = 32'h7F;
      DEPTH_16: full_scale = 32'h7FFF;
      DEPTH_24: full_scale = 32'h7F_FFFF;
      default:  full_scale = 32'h7FFF_FFFF;
    endcase
    if (ex == 8'hFF) mag = (fr != 0) ? 32'd0 : full_scale;
    else if (ex == 8'd0) mag = 32'd0;
    else if (ex >= 8'd127) mag = full_scale;
    else begin
      sh = 150 - int'(ex);
      if (sh >= 64) mag = 32'd0;
      else begin
        prod = 64'({1'b1, fr}) * 64'(full_scale);
        mag = 32'((prod + (64'd1 << (sh - 1))) >> sh);
      end
    end
    w = sgn ? (32'd0 - mag) : mag;
    case (cur_depth)
      DEPTH_8:  return {24'd0, 8'(w + 32'd128)};
      DEPTH_16: return {16'd0, w[15:0]};
      DEPTH_24: return {8'd0, w[23:0]};
      default:  return w;
    endcase
  endfunction

  // result checker
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni && done_o) begin
      if (pending_pcm.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result pcm_word=%h", pcm_word_o);
      end else begin
        want = pending_pcm.pop_front();
        if (pcm_word_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pcm_word mismatch: expected %h got %h", want, pcm_word_o);
        end
      end
    end
  end

  // wait for all results plus pipeline drain
  task automatic drain_pipe();
    while (pending_pcm.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // write the depth register while idle
  task automatic write_depth(depth_e d);
    drain_pipe();
    cfg_valid_i <= 1'b1;
    target_depth_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cur_depth = d;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one sample transaction, optionally with a known answer
  task automatic send_sample(logic [31:0] f, logic has_exp, logic [31:0] exp_word);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    float_bits_i <= f;
    do @(posedge clk_i); while (busy);
    pending_pcm.push_back(has_exp ? exp_word : encode_pcm(f));
    @(negedge clk_i);
  endtask

  // random float biased toward the interesting region
  function automatic logic [31:0] rand_float();
    logic [31:0] f;
    int          sel;
    f = $urandom();
    sel = $urandom_range(9);
    if (sel < 6) f[30:23] = 8'($urandom_range(126, 96));
    else if (sel == 6) f[30:23] = 8'($urandom_range(95, 1));
    else if (sel == 7) f[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
    else if (sel == 8) f[30:23] = 8'($urandom_range(127, 0));
    return f;
  endfunction

  row_t plan[$];

  initial begin
    depth_e depths[4];
    depths = '{DEPTH_8, DEPTH_16, DEPTH_24, DEPTH_32};
    cur_depth = DepthReset;
    // directed table: cfg rows switch depth
    plan = '{
      '{0, 32'h3F80_0000, 1, 32'h0000_7FFF},
      '{0, 32'hBF80_0000, 1, 32'h0000_8001},
      '{0, 32'h0000_0000, 1, 32'h0},
      '{0, 32'h8000_0000, 1, 32'h0},
      '{0, 32'h7FC0_0000, 1, 32'h0},
      '{0, 32'h7F80_0000, 1, 32'h0000_7FFF},
      '{0, 32'hFF80_0000, 1, 32'h0000_8001},
      '{0, 32'h0000_0001, 1, 32'h0},
      '{0, 32'h3F00_0000, 0, 32'h0},
      '{0, 32'h0080_0000, 1, 32'h0},
      '{1, 32'(DEPTH_8), 0, 32'h0},
      '{0, 32'h3F80_0000, 1, 32'h0000_00FF},
      '{0, 32'hBF80_0000, 1, 32'h0000_0001},
      '{0, 32'hFFFF_FFFF, 1, 32'h0000_0080},
      '{0, 32'hBF00_0000, 0, 32'h0},
      '{1, 32'(DEPTH_24), 0, 32'h0},
      '{0, 32'hC000_0000, 1, 32'h0080_0001},
      '{0, 32'h3EFF_FFFF, 0, 32'h0},
      '{1, 32'(DEPTH_32), 0, 32'h0},
      '{0, 32'h7F7F_FFFF, 1, 32'h7FFF_FFFF},
      '{0, 32'hFF7F_FFFF, 1, 32'h8000_0001},
      '{0, 32'h3F7F_FFFF, 0, 32'h0},
      '{0, 32'h8000_0001, 1, 32'h0}
    };
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        start <= 1'b0;
        write_depth(depth_e'(plan[i].value[1:0]));
      end else send_sample(plan[i].value, plan[i].has_exp, plan[i].exp_word);
    end
    // random phases, each depth visited in every idling regime
    for (int ph = 0; ph < 12; ph++) begin
      sender_idle_pct = (ph < 4) ? 8 : ((ph < 8) ? 63 : 0);
      start <= 1'b0;
      write_depth(depths[(ph + 1) % 4]);
      for (int k = 0; k < 136; k++) begin
        send_sample(rand_float(), 1'b0, 32'h0);
        // hold off until everything has come back
        if (ph == 5 && k == 60) begin
          start <= 1'b0;
          while (pending_pcm.size() != 0) @(posedge clk_i);
          @(negedge clk_i);
        end
      end
    end
    start <= 1'b0;
    drain_pipe();
    if (mismatches == 0 && pending_pcm.size() == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  // run time limit
  initial begin
    #2ms;
    $display("tb_top: errors");
    $finish;
  end

endmodule

@@ files.f @@
hdl/f2pcm_pkg.sv
hdl/f2pcm_mult.sv
hdl/f2pcm_round.sv
hdl/float_to_pcm_sample_encode_unit.sv
hdl/f2pcm_checker.sv
test/tb_top.sv
